// File: hdl/masked_min_max_rescale_unit_assert.svh
// assertion macros shared by the rtl
`ifndef MASKED_MIN_MAX_RESCALE_UNIT_ASSERT_SVH
`define MASKED_MIN_MAX_RESCALE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the cycle after the antecedent
`define MMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("masked_min_max_rescale_unit: next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define MMR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("masked_min_max_rescale_unit: same-cycle check failed");

`else

`define MMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define MMR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/mmr_pkg.sv
`default_nettype none

package mmr_pkg;

    // field widths
    localparam int SAMPLE_WIDTH = 32;
    localparam int VAL_W        = 16;
    localparam int DIFF_W       = SAMPLE_WIDTH + 1;
    localparam int PROD_W       = VAL_W + DIFF_W;
    localparam int REM_W        = DIFF_W + 1;
    localparam int CNT_W        = $clog2(PROD_W);
    localparam int STEP_W       = 3;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    // register map (index = paddr[3:2])
    localparam logic [1:0] REG_USE_MASK = 2'd0;
    localparam logic [1:0] REG_OUT_LOW  = 2'd1;
    localparam logic [1:0] REG_OUT_HIGH = 2'd2;

    // reset values
    localparam logic               USE_MASK_RST = 1'b1;
    localparam logic [VAL_W-1:0]   OUT_LOW_RST  = 16'sd0;
    localparam logic [VAL_W-1:0]   OUT_HIGH_RST = 16'sd32000;

    // sequencer program addresses
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_WAIT   = 3'd0;
    localparam step_t STEP_DIFF   = 3'd1;
    localparam step_t STEP_MUL    = 3'd2;
    localparam step_t STEP_DIV    = 3'd3;
    localparam step_t STEP_FINISH = 3'd4;

    // jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_SCALE_ACC,
        COND_TRIVIAL,
        COND_DIV_MORE,
        COND_OUT_FREE
    } cond_t;

    // one control word per program step
    typedef struct packed {
        logic  ready;
        logic  ld_diff;
        logic  ld_mul;
        logic  div_step;
        logic  ld_out;
        cond_t cond;
        step_t jump_to;
        step_t else_to;
    } ctrl_word_t;

    // control store
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t w;
        w = '0;
        unique case (step)
            STEP_WAIT:
            begin
                w.ready   = 1'b1;
                w.cond    = COND_SCALE_ACC;
                w.jump_to = STEP_DIFF;
                w.else_to = STEP_WAIT;
            end
            STEP_DIFF:
            begin
                w.ld_diff = 1'b1;
                w.cond    = COND_TRIVIAL;
                w.jump_to = STEP_FINISH;
                w.else_to = STEP_MUL;
            end
            STEP_MUL:
            begin
                w.ld_mul  = 1'b1;
                w.cond    = COND_ALWAYS;
                w.jump_to = STEP_DIV;
                w.else_to = STEP_DIV;
            end
            STEP_DIV:
            begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_MORE;
                w.jump_to  = STEP_DIV;
                w.else_to  = STEP_FINISH;
            end
            STEP_FINISH:
            begin
                w.ld_out  = 1'b1;
                w.cond    = COND_OUT_FREE;
                w.jump_to = STEP_WAIT;
                w.else_to = STEP_FINISH;
            end
            default:
            begin
                w.cond    = COND_ALWAYS;
                w.jump_to = STEP_WAIT;
                w.else_to = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mmr_sample_if.sv
`default_nettype none

// input sample channel
interface mmr_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic                                  first_of_block;
    logic signed [mmr_pkg::SAMPLE_WIDTH-1:0] sample_value;
    logic                                  trace_enabled;
    logic signed [mmr_pkg::VAL_W-1:0]        dip_xy;
    logic signed [mmr_pkg::VAL_W-1:0]        dip_xz;

    modport source (
        output valid, req_type, first_of_block, sample_value, trace_enabled, dip_xy, dip_xz,
        input  ready
    );

    modport sink (
        input  valid, req_type, first_of_block, sample_value, trace_enabled, dip_xy, dip_xz,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/mmr_result_if.sv
`default_nettype none

// rescaled result channel
interface mmr_result_if;
    logic                           valid;
    logic                           ready;
    logic signed [mmr_pkg::VAL_W-1:0] scaled_value;
    logic                           degenerate;

    modport source (
        output valid, scaled_value, degenerate,
        input  ready
    );

    modport sink (
        input  valid, scaled_value, degenerate,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/masked_min_max_rescale_unit.sv
// Masked min-max rescaler. A block of samples is streamed twice: measure
// transactions (req_type 0) track the minimum and maximum of the kept samples,
// restarting on first_of_block, and give no result; scale transactions
// (req_type 1) each give one result mapping the sample linearly so that the
// block minimum lands on out_low and the maximum on out_high, truncated toward
// zero and saturated to 16 bits. Samples that are not kept give zero; if the
// block had no kept sample or a zero range, kept samples give out_low and
// degenerate is set. Control is a five-step microprogram. A measure sample
// is taken in the wait step. A scale sample that needs the full mapping runs
// through accept, difference, multiply, 49 steps of the bit-serial restoring
// divider (one quotient bit per cycle over the 49-bit product) and a finish
// step; a masked or degenerate one skips from difference to finish. A finished
// result sits in an output register, so the next sample is taken while it
// waits; the finish step holds only if the previous result is still untaken.
`default_nettype none

module masked_min_max_rescale_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    mmr_sample_if.sink                         sample_in,
    mmr_result_if.source                       result_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mmr_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mmr_pkg::DATA_W-1:0]    pwdata,
    output logic      [mmr_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    `include "masked_min_max_rescale_unit_assert.svh"

    localparam int SW = mmr_pkg::SAMPLE_WIDTH;
    localparam int VW = mmr_pkg::VAL_W;
    localparam int DW = mmr_pkg::DIFF_W;
    localparam int PW = mmr_pkg::PROD_W;
    localparam int RW = mmr_pkg::REM_W;
    localparam int CW = mmr_pkg::CNT_W;

    // configuration registers
    logic                 use_mask_reg, use_mask_next;
    logic signed [VW-1:0] out_low_reg, out_low_next;
    logic signed [VW-1:0] out_high_reg, out_high_next;

    // block statistics
    logic signed [SW-1:0] block_min_reg, block_min_next;
    logic signed [SW-1:0] block_max_reg, block_max_next;
    logic                 any_kept_reg, any_kept_next;

    // sequencer and datapath
    mmr_pkg::step_t       step_reg, step_next;
    mmr_pkg::ctrl_word_t  cw;
    logic signed [SW-1:0] x_reg, x_next;
    logic                 kept_reg, kept_next;
    logic [DW-1:0]        ae_reg, ae_next;
    logic [DW-1:0]        d_reg, d_next;
    logic [VW-1:0]        as_reg, as_next;
    logic                 neg_reg, neg_next;
    logic [PW-1:0]        quo_reg, quo_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic signed [VW-1:0] out_value_reg, out_value_next;
    logic                 out_degen_reg, out_degen_next;

    logic                 cfg_wr;
    logic                 accept;
    logic                 out_free;
    logic                 kept_in;
    logic                 degen;
    logic                 cond_true;
    logic signed [SW-1:0] min_eff, max_eff;
    logic                 any_eff;
    logic signed [DW-1:0] e_diff;
    logic signed [VW:0]   span;
    logic [RW-1:0]        rem_sh;
    logic                 ge;
    logic [17:0]          q_clip;
    logic signed [19:0]   lo_ext;
    logic signed [19:0]   base;
    logic signed [VW-1:0] sat_val;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        use_mask_next = use_mask_reg;
        out_low_next  = out_low_reg;
        out_high_next = out_high_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                mmr_pkg::REG_USE_MASK: use_mask_next = pwdata[0];
                mmr_pkg::REG_OUT_LOW:  out_low_next  = pwdata[VW-1:0];
                mmr_pkg::REG_OUT_HIGH: out_high_next = pwdata[VW-1:0];
                default:               use_mask_next = use_mask_reg;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            mmr_pkg::REG_USE_MASK: prdata = {{(mmr_pkg::DATA_W-1){1'b0}}, use_mask_reg};
            mmr_pkg::REG_OUT_LOW:
                prdata = {{(mmr_pkg::DATA_W-VW){out_low_reg[VW-1]}}, out_low_reg};
            mmr_pkg::REG_OUT_HIGH:
                prdata = {{(mmr_pkg::DATA_W-VW){out_high_reg[VW-1]}}, out_high_reg};
            default:               prdata = '0;
        endcase
    end

    // control word and handshake
    assign cw              = mmr_pkg::ucode(step_reg);
    assign sample_in.ready = cw.ready;
    assign accept          = sample_in.valid & cw.ready;
    assign out_free        = ~out_valid_reg | result_out.ready;

    assign kept_in = ~use_mask_reg |
                     (sample_in.trace_enabled &
                      ((sample_in.dip_xy != '0) | (sample_in.dip_xz != '0)));
    assign degen   = ~any_kept_reg | (block_max_reg == block_min_reg);

    // jump condition select
    always_comb
    begin
        case (cw.cond)
            mmr_pkg::COND_ALWAYS:    cond_true = 1'b1;
            mmr_pkg::COND_SCALE_ACC: cond_true = accept & sample_in.req_type;
            mmr_pkg::COND_TRIVIAL:   cond_true = ~kept_reg | degen;
            mmr_pkg::COND_DIV_MORE:  cond_true = (cnt_reg != '0);
            mmr_pkg::COND_OUT_FREE:  cond_true = out_free;
            default:                 cond_true = 1'b1;
        endcase
    end

    assign step_next = cond_true ? cw.jump_to : cw.else_to;

    // min and max tracking on measure transactions
    always_comb
    begin
        min_eff = sample_in.first_of_block ? '0 : block_min_reg;
        max_eff = sample_in.first_of_block ? '0 : block_max_reg;
        any_eff = sample_in.first_of_block ? 1'b0 : any_kept_reg;
        block_min_next = block_min_reg;
        block_max_next = block_max_reg;
        any_kept_next  = any_kept_reg;
        if (accept && !sample_in.req_type)
        begin
            block_min_next = min_eff;
            block_max_next = max_eff;
            any_kept_next  = any_eff;
            if (kept_in)
            begin
                any_kept_next = 1'b1;
                if (!any_eff)
                begin
                    block_min_next = sample_in.sample_value;
                    block_max_next = sample_in.sample_value;
                end
                else
                begin
                    if (sample_in.sample_value < min_eff)
                        block_min_next = sample_in.sample_value;
                    if (sample_in.sample_value > max_eff)
                        block_max_next = sample_in.sample_value;
                end
            end
        end
    end

    // capture of each accepted sample
    assign x_next    = accept ? sample_in.sample_value : x_reg;
    assign kept_next = accept ? kept_in : kept_reg;

    // offset, range and target span
    always_comb
    begin
        e_diff = {x_reg[SW-1], x_reg} - {block_min_reg[SW-1], block_min_reg};
        span   = {out_high_reg[VW-1], out_high_reg} - {out_low_reg[VW-1], out_low_reg};
        ae_next  = ae_reg;
        d_next   = d_reg;
        as_next  = as_reg;
        neg_next = neg_reg;
        if (cw.ld_diff)
        begin
            ae_next  = e_diff[DW-1] ? DW'(-e_diff) : DW'(e_diff);
            d_next   = DW'({block_max_reg[SW-1], block_max_reg} -
                           {block_min_reg[SW-1], block_min_reg});
            as_next  = span[VW] ? VW'(-span) : VW'(span);
            neg_next = span[VW] ^ e_diff[DW-1];
        end
    end

    // product, then restoring division one quotient bit a step
    always_comb
    begin
        rem_sh   = {rem_reg[RW-2:0], quo_reg[PW-1]};
        ge       = (rem_sh >= {1'b0, d_reg});
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cw.ld_mul)
        begin
            quo_next = PW'(as_reg) * PW'(ae_reg);
            rem_next = '0;
            cnt_next = CW'(PW - 1);
        end
        else if (cw.div_step)
        begin
            quo_next = {quo_reg[PW-2:0], ge};
            rem_next = ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // offset from out_low, truncation toward zero and saturation
    always_comb
    begin
        q_clip = (|quo_reg[PW-1:17]) ? 18'h20000 : {1'b0, quo_reg[16:0]};
        lo_ext = {{4{out_low_reg[VW-1]}}, out_low_reg};
        base   = neg_reg ? (lo_ext - $signed({2'b00, q_clip}))
                         : (lo_ext + $signed({2'b00, q_clip}));
        if (rem_reg != '0)
        begin
            if (!neg_reg && base[19])
                base = base + 20'sd1;
            else if (neg_reg && !base[19] && base != '0)
                base = base - 20'sd1;
        end
        if (base > 20'sd32767)
            sat_val = 16'sh7FFF;
        else if (base < -20'sd32768)
            sat_val = 16'sh8000;
        else
            sat_val = base[VW-1:0];
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg & ~result_out.ready;
        out_value_next = out_value_reg;
        out_degen_next = out_degen_reg;
        if (cw.ld_out && out_free)
        begin
            out_valid_next = 1'b1;
            out_degen_next = degen;
            if (!kept_reg)
                out_value_next = '0;
            else if (degen)
                out_value_next = out_low_reg;
            else
                out_value_next = sat_val;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.scaled_value = out_value_reg;
    assign result_out.degenerate   = out_degen_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_mask_reg  <= mmr_pkg::USE_MASK_RST;
            out_low_reg   <= mmr_pkg::OUT_LOW_RST;
            out_high_reg  <= mmr_pkg::OUT_HIGH_RST;
            block_min_reg <= '0;
            block_max_reg <= '0;
            any_kept_reg  <= 1'b0;
            step_reg      <= mmr_pkg::STEP_WAIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            use_mask_reg  <= use_mask_next;
            out_low_reg   <= out_low_next;
            out_high_reg  <= out_high_next;
            block_min_reg <= block_min_next;
            block_max_reg <= block_max_next;
            any_kept_reg  <= any_kept_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        kept_reg      <= kept_next;
        ae_reg        <= ae_next;
        d_reg         <= d_next;
        as_reg        <= as_next;
        neg_reg       <= neg_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        out_value_reg <= out_value_next;
        out_degen_reg <= out_degen_next;
    end

    // checks
    `MMR_ASSERT_NEXT(a_scale_starts, clk, rst_n, accept && sample_in.req_type, step_reg == mmr_pkg::STEP_DIFF)
    `MMR_ASSERT_NEXT(a_finish_loads, clk, rst_n, (step_reg == mmr_pkg::STEP_FINISH) && out_free, result_out.valid)
    `MMR_ASSERT_SAME(a_div_nonzero, clk, rst_n, step_reg == mmr_pkg::STEP_DIV, d_reg != '0)

endmodule

`default_nettype wire

// File: bench/mmr_tb_pkg.sv
package mmr_tb_pkg;

    import mmr_pkg::*;

    // kinds of sample transaction
    typedef enum logic {
        REQ_MEASURE = 1'b0,
        REQ_SCALE   = 1'b1
    } req_kind_e;

    // one input sample as the bench sees it
    typedef struct {
        req_kind_e                kind;
        logic                     first;
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                     trace;
        logic signed [VAL_W-1:0]  dip_a;
        logic signed [VAL_W-1:0]  dip_b;
    } sample_t;

endpackage

// File: bench/mmr_checker.sv
module mmr_checker
    import mmr_pkg::*;
    import mmr_tb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mmr_sample_if             smp,
    mmr_result_if             res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [VAL_W-1:0] scaled;
        logic                    degen;
    } scaled_t;

    // shadow registers and block tracking state
    logic                          use_mask;
    logic signed [VAL_W-1:0]       out_low;
    logic signed [VAL_W-1:0]       out_high;
    logic signed [SAMPLE_WIDTH-1:0] blk_min;
    logic signed [SAMPLE_WIDTH-1:0] blk_max;
    logic                          blk_any_kept;

    scaled_t expected_scaled[$];
    int      mismatches;

    // linear map of x from [blk_min, blk_max] onto [out_low, out_high]
    // truncated toward zero, then saturated
    function automatic logic signed [VAL_W-1:0] rescaled(logic signed [SAMPLE_WIDTH-1:0] x);
        longint lo;
        longint span;
        longint e;
        longint d;
        longint prod;
        longint q;
        longint base;
        bit     frac;
        bit     neg;
        lo   = out_low;
        span = longint'(out_high) - lo;
        e    = longint'(x) - longint'(blk_min);
        d    = longint'(blk_max) - longint'(blk_min);
        prod = (span < 0 ? -span : span) * (e < 0 ? -e : e);
        q    = prod / d;
        frac = (prod % d) != 0;
        neg  = (span < 0) != (e < 0);
        if (!neg)
        begin
            base = lo + q;
            if (base < 0 && frac)
                base = base + 1;
        end
        else
        begin
            base = lo - q;
            if (base > 0 && frac)
                base = base - 1;
        end
        if (base > 32767)
            base = 32767;
        else if (base < -32768)
            base = -32768;
        return base[VAL_W-1:0];
    endfunction

    // update tracking on a measure sample, queue the expected result on a scale sample
    function automatic void take_sample();
        logic    kept;
        logic    degen;
        scaled_t r;
        kept = !use_mask || (smp.trace_enabled && (smp.dip_xy != 0 || smp.dip_xz != 0));
        if (smp.req_type == REQ_MEASURE)
        begin
            if (smp.first_of_block)
            begin
                blk_any_kept = 1'b0;
                blk_min      = '0;
                blk_max      = '0;
            end
            if (kept)
            begin
                if (!blk_any_kept)
                begin
                    blk_min      = smp.sample_value;
                    blk_max      = smp.sample_value;
                    blk_any_kept = 1'b1;
                end
                else
                begin
                    if (smp.sample_value < blk_min)
                        blk_min = smp.sample_value;
                    if (smp.sample_value > blk_max)
                        blk_max = smp.sample_value;
                end
            end
        end
        else
        begin
            degen = !blk_any_kept || blk_max == blk_min;
            if (!kept)
                r.scaled = '0;
            else if (degen)
                r.scaled = out_low;
            else
                r.scaled = rescaled(smp.sample_value);
            r.degen = degen;
            expected_scaled.push_back(r);
        end
    endfunction

    // monitor register writes and both channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        scaled_t exp_r;
        if (!rst_n)
        begin
            use_mask     = USE_MASK_RST;
            out_low      = OUT_LOW_RST;
            out_high     = OUT_HIGH_RST;
            blk_min      = '0;
            blk_max      = '0;
            blk_any_kept = 1'b0;
            mismatches   = 0;
            expected_scaled.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_USE_MASK: use_mask = pwdata[0];
                    REG_OUT_LOW:  out_low  = pwdata[VAL_W-1:0];
                    REG_OUT_HIGH: out_high = pwdata[VAL_W-1:0];
                    default:      ;
                endcase
            end

            // results first so a new scale sample never matches this edge's result
            if (res.valid && res.ready)
            begin
                if (expected_scaled.size() == 0)
                begin
                    $error("unexpected result: scaled_value %0d, degenerate %0b",
                           res.scaled_value, res.degenerate);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_scaled.pop_front();
                    if (res.scaled_value !== exp_r.scaled)
                    begin
                        $error("scaled_value: expected %0d, actual %0d",
                               exp_r.scaled, res.scaled_value);
                        mismatches++;
                    end
                    if (res.degenerate !== exp_r.degen)
                    begin
                        $error("degenerate: expected %0b, actual %0b",
                               exp_r.degen, res.degenerate);
                        mismatches++;
                    end
                end
            end

            if (smp.valid && smp.ready)
                take_sample();

            pending    <= expected_scaled.size();
            fail_count <= mismatches;
        end
    end

endmodule

// File: bench/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mmr_pkg::*;
    import mmr_tb_pkg::*;

    localparam int ITEMS       = 1550;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE      = 64;
    localparam int IDLE_LIMIT  = 3000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int items_sent;
    int quiet_left[2];
    bit quiet[2];

    mmr_sample_if smp();
    mmr_result_if res();

    masked_min_max_rescale_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (smp),
        .result_out (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mmr_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp        (smp),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // per-transaction wait, with occasional runs of back-to-back traffic
    function automatic int draw_wait(int side);
        if (quiet_left[side] == 0)
        begin
            quiet[side]      = ($urandom_range(0, 3) == 0);
            quiet_left[side] = $urandom_range(8, 60);
        end
        quiet_left[side]--;
        return quiet[side] ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic sample_t mk(req_kind_e k, bit first, logic [31:0] v, bit tr,
                                   logic [15:0] a, logic [15:0] b);
        sample_t s;
        s.kind  = k;
        s.first = first;
        s.value = v;
        s.trace = tr;
        s.dip_a = a;
        s.dip_b = b;
        return s;
    endfunction

    // one sample transaction; valid stays high if the next one follows at once
    task automatic push_sample(sample_t s);
        int gap;
        gap = draw_wait(0);
        if (gap > 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.valid          <= 1'b1;
        smp.req_type       <= s.kind;
        smp.first_of_block <= s.first;
        smp.sample_value   <= s.value;
        smp.trace_enabled  <= s.trace;
        smp.dip_xy         <= s.dip_a;
        smp.dip_xz         <= s.dip_b;
        do @(posedge clk); while (!smp.ready);
        items_sent++;
    endtask

    // let the block drain before touching registers or ending
    // (one edge first so the checker's count includes the last transaction)
    task automatic settle();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // setup then access phase; psel stays up across back-to-back writes
    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic configure(bit mask_on, logic [15:0] lo, logic [15:0] hi);
        apb_write(REG_USE_MASK, {31'b0, mask_on});
        apb_write(REG_OUT_LOW, {16'b0, lo});
        apb_write(REG_OUT_HIGH, {16'b0, hi});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // a measure pass then a scale pass over the same samples, with some noise
    task automatic run_block();
        int          n;
        logic [31:0] base;
        logic [31:0] spread;
        sample_t     blk[$];
        sample_t     s;
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        base = $urandom;
        case ($urandom_range(0, 5))
            0:       spread = 32'h0;
            1:       spread = 32'hF;
            2:       spread = 32'hFFF;
            3:       spread = 32'hF_FFFF;
            default: spread = 32'hFFFF_FFFF;
        endcase
        for (int i = 0; i < n; i++)
        begin
            s.kind  = REQ_MEASURE;
            s.value = base + $urandom_range(0, spread);
            if ($urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       s.value = 32'h8000_0000;
                    1:       s.value = 32'h7FFF_FFFF;
                    2:       s.value = 32'h0;
                    default: s.value = 32'hFFFF_FFFF;
                endcase
            end
            s.trace = ($urandom_range(0, 7) != 0);
            s.dip_a = '0;
            s.dip_b = '0;
            case ($urandom_range(0, 3))
                0:       ;
                1:       s.dip_a = 16'($urandom);
                2:       s.dip_b = 16'($urandom);
                default:
                begin
                    s.dip_a = 16'($urandom);
                    s.dip_b = 16'($urandom);
                end
            endcase
            // a missing or stray block mark now and then
            s.first = (i == 0);
            if ($urandom_range(0, 15) == 0)
                s.first = !s.first;
            blk.push_back(s);
            push_sample(s);
        end
        foreach (blk[i])
        begin
            s       = blk[i];
            s.kind  = REQ_SCALE;
            s.first = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0)
                s.value = $urandom;
            push_sample(s);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                s = mk(req_kind_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                       1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                push_sample(s);
            end
        end
    endtask

    // result side back-pressure
    initial
    begin
        int stall;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(1);
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
        end
    end

    // give up when nothing has moved for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
                (psel && penable && pready) || !rst_n)
                idle = 0;
            else
                idle++;
        end
        $display("** masked_min_max_rescale_unit: FAILED **");
        $finish;
    end

    // stimulus
    initial
    begin
        sample_t     directed[$];
        int          phase;
        int          phase_end;
        logic [15:0] lo;
        logic [15:0] hi;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        smp.valid          = 1'b0;
        smp.req_type       = REQ_MEASURE;
        smp.first_of_block = 1'b0;
        smp.sample_value   = '0;
        smp.trace_enabled  = 1'b0;
        smp.dip_xy         = '0;
        smp.dip_xz         = '0;
        items_sent         = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scale before anything was measured, kept and masked
        directed.push_back(mk(REQ_SCALE, 0, 32'd1234, 1, 16'd1, 16'd0));
        directed.push_back(mk(REQ_SCALE, 0, 32'd1234, 0, 16'd1, 16'd1));
        // full-range block with masked samples and an unmarked continuation
        directed.push_back(mk(REQ_MEASURE, 1, 32'h8000_0000, 1, 16'h8000, 16'h0));
        directed.push_back(mk(REQ_MEASURE, 0, 32'h7FFF_FFFF, 1, 16'h0, 16'h7FFF));
        directed.push_back(mk(REQ_MEASURE, 0, 32'h0000_1000, 0, 16'hFFFF, 16'hFFFF));
        directed.push_back(mk(REQ_MEASURE, 0, 32'h0, 1, 16'h0, 16'h0));
        directed.push_back(mk(REQ_MEASURE, 0, 32'h0000_3000, 1, 16'hFFFF, 16'hFFFF));
        directed.push_back(mk(REQ_SCALE, 0, 32'h8000_0000, 1, 16'h8000, 16'h0));
        directed.push_back(mk(REQ_SCALE, 0, 32'h7FFF_FFFF, 1, 16'h0, 16'h7FFF));
        directed.push_back(mk(REQ_SCALE, 1, 32'h0000_3000, 1, 16'hFFFF, 16'hFFFF));
        directed.push_back(mk(REQ_SCALE, 0, 32'h0000_1000, 0, 16'hFFFF, 16'hFFFF));
        directed.push_back(mk(REQ_SCALE, 0, 32'h0, 1, 16'h0, 16'h0));
        // block where nothing is kept
        directed.push_back(mk(REQ_MEASURE, 1, 32'd5, 0, 16'd1, 16'd0));
        directed.push_back(mk(REQ_SCALE, 0, 32'd5, 1, 16'd1, 16'd0));
        directed.push_back(mk(REQ_SCALE, 0, 32'd5, 0, 16'd1, 16'd0));
        // equal extremes
        directed.push_back(mk(REQ_MEASURE, 1, 32'hFFFF_FFF9, 1, 16'd3, 16'd0));
        directed.push_back(mk(REQ_MEASURE, 0, 32'hFFFF_FFF9, 1, 16'd0, 16'd3));
        directed.push_back(mk(REQ_SCALE, 0, 32'hFFFF_FFF9, 1, 16'd3, 16'd3));
        // narrow range, then scale samples inside and well outside it
        directed.push_back(mk(REQ_MEASURE, 1, 32'd0, 1, 16'd1, 16'd1));
        directed.push_back(mk(REQ_MEASURE, 0, 32'd10, 1, 16'd1, 16'd1));
        directed.push_back(mk(REQ_SCALE, 0, 32'd5, 1, 16'd1, 16'd1));
        directed.push_back(mk(REQ_SCALE, 0, 32'd1000000, 1, 16'd1, 16'd1));
        directed.push_back(mk(REQ_SCALE, 0, -32'sd1000000, 1, 16'd1, 16'd1));
        directed.push_back(mk(REQ_SCALE, 0, 32'h7FFF_FFFF, 1, 16'd1, 16'd1));
        foreach (directed[i])
            push_sample(directed[i]);

        // random blocks under a range of register settings
        phase = 0;
        while (items_sent < ITEMS)
        begin
            settle();
            case (phase)
                0:
                begin
                    configure(1'b0, 16'h8000, 16'h7FFF);
                end
                1:
                begin
                    configure(1'b1, 16'h7FFF, 16'h8000);
                end
                2:
                begin
                    configure(1'b1, 16'd5, 16'd5);
                end
                3:
                begin
                    configure(1'b0, 16'hFF9C, 16'd100);
                end
                default:
                begin
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                    configure(1'($urandom_range(0, 1)), lo, hi);
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                run_block();
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("** masked_min_max_rescale_unit: PASSED **");
        else
            $display("** masked_min_max_rescale_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mmr_pkg.sv
hdl/mmr_sample_if.sv
hdl/mmr_result_if.sv
hdl/masked_min_max_rescale_unit.sv
bench/mmr_tb_pkg.sv
bench/mmr_checker.sv
bench/tb_top.sv
